@@ rtl/dli_pkg.sv @@
// Shared types, defaults and status codes for the delta list insert block.
package dli_pkg;

  localparam int DEF_PROCESS_COUNT = 64;
  localparam int DEF_QUEUE_COUNT   = 4;

  localparam int ENTRY_W = 7;
  localparam int QUEUE_W = 3;
  localparam int DELAY_W = 31;
  localparam int NODE_W  = 7;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_ENTRY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_QUEUE = 2'd2;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_id;
    logic [QUEUE_W-1:0] queue_id;
    logic [DELAY_W-1:0] delay;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DELAY_W-1:0] stored_delay;
    logic [NODE_W-1:0]  predecessor;
    logic [NODE_W-1:0]  successor;
  } out_t;

endpackage

@@ rtl/delta_list_insert.sv @@
// Top level: delta list insert with a sequenced walk over a shared link table.
//
// Usage: drive in_req and raise start; the request is taken at a rising edge
// where start is high and busy is low. busy stays high while the list walk
// and the link updates run. One result per request appears on out_res for
// exactly one cycle, marked by out_strobe; the receiver cannot stall it.
//
// Sequence: a rejected request (entry id or queue id out of range) strobes its
// result in the next cycle and never raises busy. An accepted insert that
// passes k list entries (k capped at PROCESS_COUNT) reads the head link
// (S_HEAD), takes one walk step per entry passed (S_WALK), then updates the
// links (S_LINK, S_FIX) and strobes its result. The walk takes one step at a
// time because the link and delay tables each have one registered read port and
// the next address comes from the previous read. A new request is accepted
// in the cycle its predecessor's result is strobed.
//
// Reset: every table entry reads as its reset value (heads point to their
// tails, delays zero) through per-entry valid bits cleared at once; no
// clearing pass is needed and requests are taken right after reset.
module delta_list_insert #(
  parameter int PROCESS_COUNT = dli_pkg::DEF_PROCESS_COUNT,
  parameter int QUEUE_COUNT   = dli_pkg::DEF_QUEUE_COUNT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  dli_pkg::in_t  in_req,
  output logic          out_strobe,
  output dli_pkg::out_t out_res
);
  import dli_pkg::*;

  localparam int TABLE_SIZE = PROCESS_COUNT + 2 * QUEUE_COUNT;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int STEP_W     = $clog2(PROCESS_COUNT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;

  // Reset value of the forward link table: a head points to its own tail.
  function automatic logic [IDX_W-1:0] next_rst(input logic [IDX_W-1:0] a);
    logic [IDX_W:0] off;
    logic [IDX_W-1:0] res;
    off = {1'b0, a} - (IDX_W+1)'(PROCESS_COUNT);
    if (({1'b0, a} >= (IDX_W+1)'(PROCESS_COUNT)) && !off[0]) begin
      res = a + 1'b1;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // Treat a link outside the table as the tail.
  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] n,
                                                 input logic [IDX_W-1:0] tl);
    return ({1'b0, n} >= (IDX_W+1)'(TABLE_SIZE)) ? tl : n;
  endfunction

  function automatic logic [NODE_W-1:0] to_node(input logic [IDX_W-1:0] n);
    logic [IDX_W+NODE_W-1:0] wide;
    wide = {{NODE_W{1'b0}}, n};
    return wide[NODE_W-1:0];
  endfunction

  // Tables: forward links and relative delays, one read and one write port each.
  logic [IDX_W-1:0]   nmem [TABLE_SIZE];
  logic [DELAY_W-1:0] dmem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] nvalid_r, dvalid_r;

  logic [2:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   id_r, id_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [IDX_W-1:0]   prev_r, prev_nxt;
  logic [IDX_W-1:0]   next_r, next_nxt;
  logic [DELAY_W-1:0] key_r, key_nxt;
  logic [DELAY_W-1:0] succ_r, succ_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic               strobe_r, strobe_nxt;
  out_t               res_r, res_nxt;

  logic [IDX_W-1:0]   nrd_r;
  logic [DELAY_W-1:0] drd_r;
  logic [IDX_W-1:0]   raddr;

  logic               n_we, d_we;
  logic [IDX_W-1:0]   n_waddr, n_wdata, d_waddr;
  logic [DELAY_W-1:0] d_wdata;

  logic               accept, bad_entry, bad_queue;
  logic [IDX_W+3:0]   head_w;
  logic [IDX_W-1:0]   head_in;
  logic [IDX_W+ENTRY_W-1:0] id_w;
  logic [IDX_W-1:0]   link_nn;
  logic [DELAY_W-1:0] succ_cur;

  assign accept    = start && !busy;
  assign bad_entry = {1'b0, in_req.entry_id} >= (ENTRY_W+1)'(PROCESS_COUNT);
  assign bad_queue = {1'b0, in_req.queue_id} >= (QUEUE_W+1)'(QUEUE_COUNT);
  assign head_w    = (IDX_W+4)'(PROCESS_COUNT) + (IDX_W+4)'({in_req.queue_id, 1'b0});
  assign head_in   = head_w[IDX_W-1:0];
  assign id_w      = {{IDX_W{1'b0}}, in_req.entry_id};
  assign link_nn   = clamp_idx(nrd_r, tail_r);
  // A successor that is the new entry itself already holds the stored delay.
  assign succ_cur  = (next_r == id_r) ? key_r : succ_r;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  // Read the head link at acceptance, afterwards follow the last link read.
  assign raddr = (state_r == S_IDLE) ? head_in : link_nn;

  always_comb begin
    state_nxt  = state_r;
    id_nxt     = id_r;
    tail_nxt   = tail_r;
    prev_nxt   = prev_r;
    next_nxt   = next_r;
    key_nxt    = key_r;
    succ_nxt   = succ_r;
    steps_nxt  = steps_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    n_we       = 1'b0;
    d_we       = 1'b0;
    n_waddr    = id_r;
    n_wdata    = next_r;
    d_waddr    = id_r;
    d_wdata    = key_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (bad_entry || bad_queue) begin
            strobe_nxt           = 1'b1;
            res_nxt              = '0;
            res_nxt.status       = bad_entry ? STATUS_BAD_ENTRY : STATUS_BAD_QUEUE;
          end else begin
            id_nxt    = id_w[IDX_W-1:0];
            tail_nxt  = head_in + 1'b1;
            prev_nxt  = head_in;
            key_nxt   = in_req.delay;
            steps_nxt = '0;
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        // Head link is back; the table read at that node is already issued.
        next_nxt  = link_nn;
        state_nxt = (link_nn == tail_r) ? S_LINK : S_WALK;
      end
      S_WALK: begin
        // Read data belongs to next_r, which is never the tail here.
        if (steps_r == STEP_W'(PROCESS_COUNT) || drd_r > key_r) begin
          succ_nxt  = drd_r;
          state_nxt = S_LINK;
        end else begin
          key_nxt   = key_r - drd_r;
          prev_nxt  = next_r;
          next_nxt  = link_nn;
          steps_nxt = steps_r + 1'b1;
          if (link_nn == tail_r) begin
            state_nxt = S_LINK;
          end
        end
      end
      S_LINK: begin
        // Link the new entry forward and store its remaining delay.
        n_we      = 1'b1;
        d_we      = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        // Hook the predecessor to the entry, trim the successor unless it is the tail, and strobe the result.
        n_we    = 1'b1;
        n_waddr = prev_r;
        n_wdata = id_r;
        d_waddr = next_r;
        d_wdata = (succ_cur >= key_r) ? (succ_cur - key_r) : '0;
        d_we    = (next_r != tail_r);
        strobe_nxt            = 1'b1;
        res_nxt.status        = STATUS_OK;
        res_nxt.stored_delay  = key_r;
        res_nxt.predecessor   = to_node(prev_r);
        res_nxt.successor     = to_node(next_r);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      nmem[n_waddr] <= n_wdata;
    end
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    nrd_r <= nvalid_r[raddr] ? nmem[raddr] : next_rst(raddr);
    drd_r <= dvalid_r[raddr] ? dmem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvalid_r <= '0;
      dvalid_r <= '0;
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      if (n_we) begin
        nvalid_r[n_waddr] <= 1'b1;
      end
      if (d_we) begin
        dvalid_r[d_waddr] <= 1'b1;
      end
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    tail_r  <= tail_nxt;
    prev_r  <= prev_nxt;
    next_r  <= next_nxt;
    key_r   <= key_nxt;
    succ_r  <= succ_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
  end

endmodule

@@ rtl/dli_checker.sv @@
// Port-level checks for the delta list insert block, bound to its top level.
module dli_checker #(
  parameter int PROCESS_COUNT = dli_pkg::DEF_PROCESS_COUNT,
  parameter int QUEUE_COUNT   = dli_pkg::DEF_QUEUE_COUNT
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input dli_pkg::in_t  in_req,
  input logic          out_strobe,
  input dli_pkg::out_t out_res
);
  import dli_pkg::*;

  logic bad_entry, bad_queue, acc;

  assign acc       = start && !busy;
  assign bad_entry = {1'b0, in_req.entry_id} >= (ENTRY_W+1)'(PROCESS_COUNT);
  assign bad_queue = {1'b0, in_req.queue_id} >= (QUEUE_W+1)'(QUEUE_COUNT);

  // A rejected entry id answers in the next cycle with the bad-entry code.
  a_bad_entry: assert property (@(posedge clk) disable iff (!rst_n)
    acc && bad_entry |=> out_strobe && out_res.status == STATUS_BAD_ENTRY)
    else $error("bad entry id not reported");

  // A valid insert starts the sequencer: busy next cycle, no result yet.
  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !bad_entry && !bad_queue |=> busy && !out_strobe)
    else $error("valid insert did not start a walk");

  // Results only come out once the sequencer is back at rest.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while busy");

  // Rejected requests carry zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.status != STATUS_OK |->
      out_res.stored_delay == '0 && out_res.predecessor == '0 &&
      out_res.successor == '0)
    else $error("rejected result has nonzero fields");

endmodule

bind delta_list_insert dli_checker #(
  .PROCESS_COUNT(PROCESS_COUNT),
  .QUEUE_COUNT  (QUEUE_COUNT)
) u_dli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_strobe(out_strobe),
  .out_res   (out_res)
);
